>>> hdl/cobs_enc_pkg.sv
// Shared types and constants of the COBS frame encoder.
`default_nettype none
package cobs_enc_pkg;

   localparam int ADDR_W       = 13;
   localparam int BYTE_W       = 8;
   localparam int MAX_PAYLOAD  = 4096;
   localparam logic [BYTE_W-1:0] RUN_FULL  = 8'hFF;
   localparam logic [BYTE_W-1:0] RUN_START = 8'h01;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_FILL_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] write_address;
      logic [BYTE_W-1:0] write_value;
      logic              frame_done;
      logic [ADDR_W-1:0] encoded_length;
      logic              overflow;
   } result_type;

   // One accepted byte, already worked out into one or two results.
   typedef struct packed {
      logic       two_results;
      result_type first;
      result_type second;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

>>> hdl/cobs_enc_if.sv
// Valid/ready channel interfaces for the byte input and the write results.
`default_nettype none
interface cobs_enc_req_if;
   logic                             valid;
   logic                             ready;
   logic [cobs_enc_pkg::BYTE_W-1:0] data_byte;
   logic                             frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface cobs_enc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             write_enable;
   logic [cobs_enc_pkg::ADDR_W-1:0] write_address;
   logic [cobs_enc_pkg::BYTE_W-1:0] write_value;
   logic                             frame_done;
   logic [cobs_enc_pkg::ADDR_W-1:0] encoded_length;
   logic                             overflow;

   modport source (output valid, output write_enable, output write_address,
                   output write_value, output frame_done, output encoded_length,
                   output overflow, input ready);
   modport sink   (input valid, input write_enable, input write_address,
                   input write_value, input frame_done, input encoded_length,
                   input overflow, output ready);
endinterface
`default_nettype wire

>>> hdl/cobs_enc_front.sv
// Front end: accepts payload bytes, keeps the encoder state and forms result entries.
`default_nettype none
module cobs_enc_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   cobs_enc_req_if.sink                        req,
   input  wire cobs_enc_pkg::queue_status_type queue_status,
   output logic                                push_valid,
   output cobs_enc_pkg::entry_type             push_entry
);
   import cobs_enc_pkg::*;

   logic [ADDR_W-1:0] next_addr_ff, next_addr_in;
   logic [ADDR_W-1:0] slot_addr_ff, slot_addr_in;
   logic [BYTE_W-1:0] run_code_ff, run_code_in;
   logic [ADDR_W-1:0] count_ff, count_in;

   logic              accept;
   logic              over;
   logic              nonzero;
   logic [1:0]        num;
   result_type        res0;
   result_type        res1;
   result_type        code_res;

   function automatic result_type make_write(input logic [ADDR_W-1:0] addr,
                                             input logic [BYTE_W-1:0] value,
                                             input logic              ovf);
      result_type r;
      r                = '0;
      r.write_enable   = 1'b1;
      r.write_address  = addr;
      r.write_value    = value;
      r.overflow       = ovf;
      return r;
   endfunction

   assign req.ready = !reset && !queue_status.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      next_addr_in = next_addr_ff;
      slot_addr_in = slot_addr_ff;
      run_code_in  = run_code_ff;
      count_in     = count_ff;
      num          = 2'd0;
      res0         = '0;
      res1         = '0;
      code_res     = '0;
      over         = (count_ff >= ADDR_W'(MAX_PAYLOAD));
      nonzero      = (req.data_byte != '0);

      if (!over) begin
         count_in = count_ff + ADDR_W'(1);
         if (nonzero) begin
            res0         = make_write(next_addr_in, req.data_byte, 1'b0);
            num          = 2'd1;
            next_addr_in = next_addr_in + ADDR_W'(1);
            run_code_in  = run_code_in + BYTE_W'(1);
         end
         // A zero byte or a full run closes the block at its code slot.
         if (!nonzero || run_code_in == RUN_FULL) begin
            code_res = make_write(slot_addr_in, run_code_in, 1'b0);
            if (num == 2'd0) begin
               res0 = code_res;
            end else begin
               res1 = code_res;
            end
            num          = num + 2'd1;
            run_code_in  = RUN_START;
            slot_addr_in = next_addr_in;
            if (!nonzero || !req.frame_end) begin
               next_addr_in = next_addr_in + ADDR_W'(1);
            end
         end
      end else if (!req.frame_end) begin
         res0          = '0;
         res0.overflow = 1'b1;
         num           = 2'd1;
      end

      if (req.frame_end) begin
         // The pending code is stored only when its slot is below the running address.
         if (slot_addr_in < next_addr_in && num != 2'd2) begin
            code_res = make_write(slot_addr_in, run_code_in, over);
            if (num == 2'd0) begin
               res0 = code_res;
            end else begin
               res1 = code_res;
            end
            num = num + 2'd1;
         end
         if (num == 2'd0) begin
            res0          = '0;
            res0.overflow = over;
            num           = 2'd1;
         end
         if (num == 2'd2) begin
            res1.frame_done     = 1'b1;
            res1.encoded_length = next_addr_in;
         end else begin
            res0.frame_done     = 1'b1;
            res0.encoded_length = next_addr_in;
         end
         next_addr_in = ADDR_W'(1);
         slot_addr_in = '0;
         run_code_in  = RUN_START;
         count_in     = '0;
      end
   end

   assign push_valid             = accept;
   assign push_entry.two_results = (num == 2'd2);
   assign push_entry.first       = res0;
   assign push_entry.second      = res1;

   always_ff @(posedge clock) begin
      if (reset) begin
         next_addr_ff <= ADDR_W'(1);
         slot_addr_ff <= '0;
         run_code_ff  <= RUN_START;
         count_ff     <= '0;
      end else if (accept) begin
         next_addr_ff <= next_addr_in;
         slot_addr_ff <= slot_addr_in;
         run_code_ff  <= run_code_in;
         count_ff     <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/cobs_enc_queue.sv
// Short queue of result entries between the front end and the output stage.
`default_nettype none
module cobs_enc_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push_valid,
   input  wire cobs_enc_pkg::entry_type   push_entry,
   input  wire logic                      pop,
   output cobs_enc_pkg::entry_type        head_entry,
   output cobs_enc_pkg::queue_status_type status
);
   import cobs_enc_pkg::*;

   entry_type               slots [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_FILL_W-1:0] fill_ff, fill_in;
   logic                    do_push;
   logic                    do_pop;

   assign status.full  = (fill_ff == QUEUE_FILL_W'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_entry   = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QUEUE_FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QUEUE_FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/cobs_enc_back.sv
// Output stage: splits queued entries into single results and drives the result channel.
`default_nettype none
module cobs_enc_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cobs_enc_pkg::entry_type        head_entry,
   input  wire cobs_enc_pkg::queue_status_type queue_status,
   output logic                                pop,
   cobs_enc_rsp_if.source                      rsp
);
   import cobs_enc_pkg::*;

   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   result_type pend_ff, pend_in;
   logic       pend_valid_ff, pend_valid_in;
   logic       load;

   // The output register can take a new result when it is empty or being transferred.
   assign load = !out_valid_ff || rsp.ready;
   assign pop  = load && !pend_valid_ff && !queue_status.empty;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (load) begin
         if (pend_valid_ff) begin
            out_in        = pend_ff;
            out_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
         end else if (!queue_status.empty) begin
            out_in        = head_entry.first;
            out_valid_in  = 1'b1;
            pend_in       = head_entry.second;
            pend_valid_in = head_entry.two_results;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.write_enable   = out_ff.write_enable;
   assign rsp.write_address  = out_ff.write_address;
   assign rsp.write_value    = out_ff.write_value;
   assign rsp.frame_done     = out_ff.frame_done;
   assign rsp.encoded_length = out_ff.encoded_length;
   assign rsp.overflow       = out_ff.overflow;

endmodule
`default_nettype wire

>>> hdl/cobs_frame_encoder_top.sv
// COBS frame encoder: payload bytes in, buffer writes and frame lengths out.
//
// The req channel carries one payload byte per transfer, with frame_end set
// on the last byte of a frame. The rsp channel carries buffer writes as
// address/value pairs; the last result of a frame has frame_done set and
// encoded_length holding the total encoded size. Bytes past the frame
// capacity are dropped and their results carry overflow.
// A byte gives one or two results. The first result of a byte passes through
// the queue and the output register before it is valid on rsp. The front end
// takes one byte per cycle while the four-entry queue has room; the output
// stage sends one result per cycle while rsp.ready is high, so a byte that gives
// two results sends them one after the other, and a run of such bytes is
// limited by the output register, not by the front end.
// Reset clears the queue and the output stage and starts a fresh frame at
// address one with its code slot at address zero. When the receiver stalls,
// the output holds its result, the queue fills and req.ready then drops
// until space frees up.
`default_nettype none
module cobs_frame_encoder_top (
   input  wire logic      clock,
   input  wire logic      reset,
   cobs_enc_req_if.sink   req,
   cobs_enc_rsp_if.source rsp
);
   import cobs_enc_pkg::*;

   logic             push_valid;
   entry_type        push_entry;
   entry_type        head_entry;
   queue_status_type queue_status;
   logic             pop;

   cobs_enc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_entry   (push_entry)
   );

   cobs_enc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   cobs_enc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (head_entry),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp          (rsp)
   );

endmodule
`default_nettype wire

>>> bench/cobs_enc_tb_pkg.sv
// Scoreboard class that predicts and checks the buffer writes of the COBS frame encoder.
`default_nettype none
package cobs_enc_tb_pkg;

   timeunit 1ns;
   timeprecision 1ps;

   import cobs_enc_pkg::*;

   class cobs_write_scoreboard;

      result_type        pending_writes[$];
      int                errors;
      logic [ADDR_W-1:0] write_ptr;
      logic [ADDR_W-1:0] code_slot;
      logic [BYTE_W-1:0] run_code;
      logic [ADDR_W-1:0] frame_bytes;

      function new();
         errors = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         write_ptr   = ADDR_W'(1);
         code_slot   = '0;
         run_code    = RUN_START;
         frame_bytes = '0;
      endfunction

      function result_type make_result(logic we, logic [ADDR_W-1:0] addr,
                                       logic [BYTE_W-1:0] value, logic ovf);
         result_type r;
         r.write_enable   = we;
         r.write_address  = addr;
         r.write_value    = value;
         r.frame_done     = 1'b0;
         r.encoded_length = '0;
         r.overflow       = ovf;
         return r;
      endfunction

      // Works out the writes that one accepted byte causes.
      function void encode_byte(logic [BYTE_W-1:0] data, logic last);
         result_type step_writes[2];
         int         n;
         logic       dropped;
         n       = 0;
         dropped = (frame_bytes >= ADDR_W'(MAX_PAYLOAD));
         if (!dropped) begin
            frame_bytes = frame_bytes + ADDR_W'(1);
            if (data != '0) begin
               step_writes[n] = make_result(1'b1, write_ptr, data, 1'b0);
               n++;
               write_ptr = write_ptr + ADDR_W'(1);
               run_code  = run_code + BYTE_W'(1);
            end
            if (data == '0 || run_code == RUN_FULL) begin
               step_writes[n] = make_result(1'b1, code_slot, run_code, 1'b0);
               n++;
               run_code  = RUN_START;
               code_slot = write_ptr;
               if (data == '0 || !last) begin
                  write_ptr = write_ptr + ADDR_W'(1);
               end
            end
         end
         if (last) begin
            // The pending code only goes out when its slot lies below the write pointer.
            if (code_slot < write_ptr && n < 2) begin
               step_writes[n] = make_result(1'b1, code_slot, run_code, dropped);
               n++;
            end
            if (n == 0) begin
               step_writes[0] = make_result(1'b0, '0, '0, dropped);
               n = 1;
            end
            step_writes[n-1].frame_done     = 1'b1;
            step_writes[n-1].encoded_length = write_ptr;
            restart_frame();
         end else if (dropped) begin
            step_writes[0] = make_result(1'b0, '0, '0, 1'b1);
            n = 1;
         end
         for (int i = 0; i < n; i++) begin
            pending_writes.push_back(step_writes[i]);
         end
      endfunction

      function void compare_field(string field, logic [ADDR_W-1:0] want,
                                  logic [ADDR_W-1:0] got);
         if (want !== got) begin
            if (errors < 50) begin
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
            errors++;
         end
      endfunction

      function void check_write(result_type got);
         result_type want;
         if (pending_writes.size() == 0) begin
            if (errors < 50) begin
               $display("%0t: unexpected result, expected none, actual we=%0b addr=%0d value=%0h",
                        $time, got.write_enable, got.write_address, got.write_value);
            end
            errors++;
            return;
         end
         want = pending_writes.pop_front();
         compare_field("write_enable", ADDR_W'(want.write_enable),
                       ADDR_W'(got.write_enable));
         compare_field("write_address", want.write_address, got.write_address);
         compare_field("write_value", ADDR_W'(want.write_value),
                       ADDR_W'(got.write_value));
         compare_field("frame_done", ADDR_W'(want.frame_done), ADDR_W'(got.frame_done));
         compare_field("encoded_length", want.encoded_length, got.encoded_length);
         compare_field("overflow", ADDR_W'(want.overflow), ADDR_W'(got.overflow));
      endfunction

   endclass

endpackage
`default_nettype wire

>>> bench/tb_top.sv
// Top-level testbench of the COBS frame encoder: stimulus, handshakes and final verdict.
`default_nettype none
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import cobs_enc_pkg::*;
   import cobs_enc_tb_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 40;

   typedef logic [BYTE_W-1:0] byte_list_type[$];

   logic clock = 1'b0;
   logic reset;
   bit   no_idle = 1'b0;
   bit   hold_request = 1'b0;
   int   stall_cycles = 0;

   cobs_write_scoreboard sb;

   cobs_enc_req_if req_ch();
   cobs_enc_rsp_if rsp_ch();

   cobs_frame_encoder_top i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [BYTE_W-1:0] pick_byte(bit nonzero);
      int unsigned roll;
      roll = $urandom_range(99);
      if (nonzero) begin
         return BYTE_W'($urandom_range(255, 1));
      end
      if (roll < 25) begin
         return 8'h00;
      end
      if (roll < 33) begin
         return 8'hFF;
      end
      if (roll < 38) begin
         return 8'h01;
      end
      return BYTE_W'($urandom_range(255));
   endfunction

   function automatic byte_list_type random_frame(int len, bit nonzero);
      byte_list_type frame;
      for (int i = 0; i < len; i++) begin
         frame.push_back(pick_byte(nonzero));
      end
      return frame;
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last);
      while (!no_idle && $urandom_range(99) < 9) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= data;
      req_ch.frame_end <= last;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_frame(input byte_list_type frame);
      for (int i = 0; i < frame.size(); i++) begin
         send_byte(frame[i], i == frame.size() - 1);
      end
   endtask

   // Input and result monitors see the values that were present at the edge.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         sb.encode_byte(req_ch.data_byte, req_ch.frame_end);
      end
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.write_enable   = rsp_ch.write_enable;
         got.write_address  = rsp_ch.write_address;
         got.write_value    = rsp_ch.write_value;
         got.frame_done     = rsp_ch.frame_done;
         got.encoded_length = rsp_ch.encoded_length;
         got.overflow       = rsp_ch.overflow;
         sb.check_write(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Receiver: random back-pressure, plus one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (hold_request && hold_left == 0) begin
            hold_request = 1'b0;
            hold_left    = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 9);
         end
         @(posedge clock);
      end
   end

   initial begin
      int random_sent;
      int len;
      sb = new();
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.frame_end <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Short frames at the field extremes.
      send_frame({8'h00});
      send_frame({8'hFF});
      send_frame({8'h00, 8'h00});
      send_frame({8'h01, 8'h00, 8'h00, 8'h80});
      send_frame({8'h55, 8'hAA, 8'h7F, 8'hFE});
      send_frame({8'h11, 8'h00});
      send_frame({8'hFF, 8'h00, 8'hFF});

      // Full runs of nonzero bytes: the first closes a block on its last byte,
      // the second one byte before its end and meets a long receiver hold-off.
      no_idle = 1'b1;
      send_frame(random_frame(254, 1'b1));
      hold_request = 1'b1;
      send_frame(random_frame(255, 1'b1));
      no_idle = 1'b0;

      // Random frames with zero bytes and idles on both sides.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         send_frame(random_frame(len, 1'b0));
         random_sent += len;
      end

      req_ch.valid <= 1'b0;
      while (sb.pending_writes.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
